@@ rtl/core/ffi_pkg.sv @@
package ffi_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 54;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLD_BLEND   = 3'd0,
    CFG_INNER_RAD_SQ = 3'd1,
    CFG_OUTER_RAD_SQ = 3'd2,
    CFG_GLOBAL_SCALE = 3'd3,
    CFG_ROT_ENABLE   = 3'd4,
    CFG_ROT_ROW_A    = 3'd5,
    CFG_ROT_ROW_B    = 3'd6,
    CFG_ROT_ROW_C    = 3'd7
  } cfg_idx_t;

  // reset values of the registers
  localparam logic [16:0] RST_FOLD_BLEND   = 17'd52429;
  localparam logic [31:0] RST_INNER_RAD_SQ = 32'd16384;
  localparam logic [31:0] RST_OUTER_RAD_SQ = 32'd65536;
  localparam logic [31:0] RST_GLOBAL_SCALE = 32'd131072;
  localparam logic [53:0] RST_ROT_ROW_A    = 54'd65536;
  localparam logic [53:0] RST_ROT_ROW_B    = 54'd4294967296;
  localparam logic [53:0] RST_ROT_ROW_C    = 54'd17179869184;

  // rotation coefficients: signed Q2.16, three to a row
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 16;

  localparam logic [30:0] MAG_MAX = 31'h7fffffff;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        deriv_in;
  } ffi_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic [31:0]        deriv_out;
    logic               saturated;
  } ffi_out_t;

  // magnitudes (sorted from S2 on), derivative and sticky clip flag along the pipe
  typedef struct packed {
    logic [2:0][30:0] m;
    logic [31:0]      de;
    logic             sat;
  } ffi_pt_t;

endpackage

@@ rtl/core/fractal_fold_iteration_core.sv @@
// Fold iteration core: one point (x,y,z) plus its running derivative per transfer.
// Input: raise start with in_item; the item is taken at an edge where start is
//   high and busy is low. busy is never raised, so one item may go in every cycle.
// Output: out_strobe is high for exactly one cycle with out_item; the receiver
//   must take it then, there is no back-pressure and nothing ever waits.
// Config: cfg_we/cfg_idx/cfg_wdata write one register per edge, no read-back.
//   Write only while the pipe is empty.
// Pipeline: most stages are the fold divider, one quotient bit per stage over
//   32 + FRAC_BITS stages; the other 13 stages are abs/sort, two rounds of squares
//   for the shrink and the fold test, the split fold multiply, the scale and rotation.
// Throughput: one item per cycle, fully pipelined, valid bit travels with data.
// Reset (rst_n low, synchronous): all valid bits clear, items in flight are
//   dropped, configuration returns to its default values.
module fractal_fold_iteration_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ffi_pkg::ffi_in_t                    in_item,
  output logic                                out_strobe,
  output ffi_pkg::ffi_out_t                   out_item,
  input  logic                                cfg_we,
  input  logic [ffi_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ffi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int FB  = FRAC_BITS;
  localparam int QW  = 32 + FB;      // dividend / quotient width of the fold factor
  localparam int LO  = QW / 2;       // fold multiply split
  localparam int HI  = QW - LO;
  localparam int OBW = FB + 1;       // width of (1 - blend)
  localparam int LAT = 13 + QW;
  localparam logic [63:0] ONE_R2 = 64'd1 << (2 * FB);
  localparam logic [63:0] ONE_64 = 64'd1 << FB;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [16:0] fold_blend_r;
  logic [31:0] inner_r;
  logic [31:0] outer_r;
  logic [31:0] scale_r;
  logic        rot_en_r;
  logic [2:0][ffi_pkg::CFG_DATA_W-1:0] rot_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_blend_r <= ffi_pkg::RST_FOLD_BLEND;
      inner_r      <= ffi_pkg::RST_INNER_RAD_SQ;
      outer_r      <= ffi_pkg::RST_OUTER_RAD_SQ;
      scale_r      <= ffi_pkg::RST_GLOBAL_SCALE;
      rot_en_r     <= 1'b0;
      rot_row_r[0] <= ffi_pkg::RST_ROT_ROW_A;
      rot_row_r[1] <= ffi_pkg::RST_ROT_ROW_B;
      rot_row_r[2] <= ffi_pkg::RST_ROT_ROW_C;
    end else if (cfg_we) begin
      unique case (ffi_pkg::cfg_idx_t'(cfg_idx))
        ffi_pkg::CFG_FOLD_BLEND:   fold_blend_r <= cfg_wdata[16:0];
        ffi_pkg::CFG_INNER_RAD_SQ: inner_r      <= cfg_wdata[31:0];
        ffi_pkg::CFG_OUTER_RAD_SQ: outer_r      <= cfg_wdata[31:0];
        ffi_pkg::CFG_GLOBAL_SCALE: scale_r      <= cfg_wdata[31:0];
        ffi_pkg::CFG_ROT_ENABLE:   rot_en_r     <= cfg_wdata[0];
        ffi_pkg::CFG_ROT_ROW_A:    rot_row_r[0] <= cfg_wdata;
        ffi_pkg::CFG_ROT_ROW_B:    rot_row_r[1] <= cfg_wdata;
        ffi_pkg::CFG_ROT_ROW_C:    rot_row_r[2] <= cfg_wdata;
      endcase
    end
  end

  // fully pipelined: never busy
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // S1: magnitudes, most negative value clips to 2^31-1
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  ffi_pkg::ffi_pt_t s1_pt_r, s1_pt_nxt;
  logic [2:0][31:0] in_c;
  logic [2:0][31:0] in_abs;

  always_comb begin
    in_c[0] = in_item.coord_x;
    in_c[1] = in_item.coord_y;
    in_c[2] = in_item.coord_z;
    s1_pt_nxt.sat = 1'b0;
    s1_pt_nxt.de  = in_item.deriv_in;
    for (int i = 0; i < 3; i++) begin
      in_abs[i] = in_c[i][31] ? (~in_c[i] + 32'd1) : in_c[i];
      if (in_abs[i][31]) begin
        s1_pt_nxt.m[i] = ffi_pkg::MAG_MAX;
        s1_pt_nxt.sat  = 1'b1;
      end else begin
        s1_pt_nxt.m[i] = in_abs[i][30:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S2: three compare-swaps into descending order
  // ---------------------------------------------------------------------------
  logic             s2_valid_r;
  ffi_pkg::ffi_pt_t s2_pt_r, s2_pt_nxt;
  logic [30:0]      sa, sb, sc, st;

  always_comb begin
    sa = s1_pt_r.m[0];
    sb = s1_pt_r.m[1];
    sc = s1_pt_r.m[2];
    st = '0;
    if (sc > sb) begin
      st = sb; sb = sc; sc = st;
    end
    if (sb > sa) begin
      st = sa; sa = sb; sb = st;
    end
    if (sc > sb) begin
      st = sb; sb = sc; sc = st;
    end
    s2_pt_nxt      = s1_pt_r;
    s2_pt_nxt.m[0] = sa;
    s2_pt_nxt.m[1] = sb;
    s2_pt_nxt.m[2] = sc;
  end

  // ---------------------------------------------------------------------------
  // S3/S4: squares, then radius test against 1.0
  // ---------------------------------------------------------------------------
  logic             s3_valid_r, s4_valid_r;
  ffi_pkg::ffi_pt_t s3_pt_r, s4_pt_r;
  logic [2:0][61:0] s3_sq_r, s3_sq_nxt;
  logic [63:0]      s4_r2;
  logic             s4_big_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_sq_nxt[i] = s2_pt_r.m[i] * s2_pt_r.m[i];
    end
  end

  assign s4_r2 = 64'(s3_sq_r[0]) + 64'(s3_sq_r[1]) + 64'(s3_sq_r[2]);

  // ---------------------------------------------------------------------------
  // S5: shrink by (1 - blend) when r2 >= 1.0, blend above 1.0 acts as 1.0
  // ---------------------------------------------------------------------------
  logic             s5_valid_r;
  ffi_pkg::ffi_pt_t s5_pt_r, s5_pt_nxt;
  logic [31:0]      blend32, one32, bc32, omb32;
  logic [OBW-1:0]   omb;
  logic [2:0][30+OBW:0] s5_prod;

  always_comb begin
    blend32   = 32'(fold_blend_r);
    one32     = 32'd1 << FB;
    bc32      = (blend32 > one32) ? one32 : blend32;
    omb32     = one32 - bc32;
    omb       = omb32[OBW-1:0];
    s5_pt_nxt = s4_pt_r;
    for (int i = 0; i < 3; i++) begin
      s5_prod[i] = s4_pt_r.m[i] * omb;
      if (s4_big_r) begin
        s5_pt_nxt.m[i] = s5_prod[i][FB+30:FB];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S6/S7: squares again, pick fold and divisor
  // ---------------------------------------------------------------------------
  logic             s6_valid_r;
  ffi_pkg::ffi_pt_t s6_pt_r;
  logic [2:0][61:0] s6_sq_r, s6_sq_nxt;
  logic [63:0]      s7_r2;
  logic [QW-1:0]    inner_sh, outer_sh;
  logic [31:0]      s7_rq;
  logic             s7_in, s7_mid;
  logic [31:0]      s7_dvs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_sq_nxt[i] = s5_pt_r.m[i] * s5_pt_r.m[i];
    end
  end

  always_comb begin
    s7_r2    = 64'(s6_sq_r[0]) + 64'(s6_sq_r[1]) + 64'(s6_sq_r[2]);
    inner_sh = {inner_r, {FB{1'b0}}};
    outer_sh = {outer_r, {FB{1'b0}}};
    s7_in    = s7_r2 < 64'(inner_sh);
    s7_mid   = s7_r2 < 64'(outer_sh);
    // when r2 is below outer << FB (fold case), the truncated radius fits 32 bits
    s7_rq    = s7_r2[FB+31:FB];
    if (s7_rq == 32'd0) begin
      s7_rq = 32'd1;
    end
    s7_dvs   = s7_in ? inner_r : s7_rq;
  end

  // ---------------------------------------------------------------------------
  // divider: (outer << FB) / divisor, one quotient bit per stage, restoring
  // ---------------------------------------------------------------------------
  logic             d_valid_r [QW+1];
  ffi_pkg::ffi_pt_t d_pt_r    [QW+1];
  logic             d_fold_r  [QW+1];
  logic [QW-1:0]    d_q_r     [QW+1];
  logic [31:0]      d_dvs_r   [QW];
  logic [31:0]      d_rem_r   [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      s4_valid_r   <= 1'b0;
      s5_valid_r   <= 1'b0;
      s6_valid_r   <= 1'b0;
      d_valid_r[0] <= 1'b0;
    end else begin
      s1_valid_r   <= start && !busy;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      s4_valid_r   <= s3_valid_r;
      s5_valid_r   <= s4_valid_r;
      s6_valid_r   <= s5_valid_r;
      d_valid_r[0] <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pt_r    <= s1_pt_nxt;
    s2_pt_r    <= s2_pt_nxt;
    s3_pt_r    <= s2_pt_r;
    s3_sq_r    <= s3_sq_nxt;
    s4_pt_r    <= s3_pt_r;
    s4_big_r   <= s4_r2 >= ONE_R2;
    s5_pt_r    <= s5_pt_nxt;
    s6_pt_r    <= s5_pt_r;
    s6_sq_r    <= s6_sq_nxt;
    d_pt_r[0]  <= s6_pt_r;
    d_fold_r[0] <= s7_mid || s7_in;
    d_dvs_r[0] <= s7_dvs;
    d_rem_r[0] <= 32'd0;
    d_q_r[0]   <= '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic        dbit;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    if (B >= FB) begin : g_obit
      assign dbit = outer_r[B-FB];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end

    assign trial = {d_rem_r[j], dbit};
    assign diff  = trial - {1'b0, d_dvs_r[j]};
    assign ge    = trial >= {1'b0, d_dvs_r[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_valid_r[j+1] <= 1'b0;
      end else begin
        d_valid_r[j+1] <= d_valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      d_pt_r[j+1]   <= d_pt_r[j];
      d_fold_r[j+1] <= d_fold_r[j];
      d_q_r[j+1]    <= {d_q_r[j][QW-2:0], ge};
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        d_dvs_r[j+1] <= d_dvs_r[j];
        d_rem_r[j+1] <= ge ? diff[31:0] : trial[31:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // M1/M2: fold multiply in two halves, then clip
  // ---------------------------------------------------------------------------
  logic                    m1_valid_r, m2_valid_r;
  ffi_pkg::ffi_pt_t        m1_pt_r, m2_pt_r, m2_pt_nxt;
  logic                    m1_fold_r;
  logic [3:0][31:0]        m1_op;
  logic [3:0][32+LO-1:0]   m1_pl_r, m1_pl_nxt;
  logic [3:0][32+HI-1:0]   m1_ph_r, m1_ph_nxt;
  logic [3:0][32+QW-1:0]   m2_full;
  logic [3:0][63:0]        m2_p;

  always_comb begin
    m1_op[0] = {1'b0, d_pt_r[QW].m[0]};
    m1_op[1] = {1'b0, d_pt_r[QW].m[1]};
    m1_op[2] = {1'b0, d_pt_r[QW].m[2]};
    m1_op[3] = d_pt_r[QW].de;
    for (int i = 0; i < 4; i++) begin
      m1_pl_nxt[i] = m1_op[i] * d_q_r[QW][LO-1:0];
      m1_ph_nxt[i] = m1_op[i] * d_q_r[QW][QW-1:LO];
    end
  end

  always_comb begin
    m2_pt_nxt = m1_pt_r;
    for (int i = 0; i < 4; i++) begin
      m2_full[i] = {m1_ph_r[i], {LO{1'b0}}} + (32+QW)'(m1_pl_r[i]);
      m2_p[i]    = m2_full[i][32+QW-1:FB];
    end
    if (m1_fold_r) begin
      for (int i = 0; i < 3; i++) begin
        if (m2_p[i] > 64'h7fffffff) begin
          m2_pt_nxt.m[i] = ffi_pkg::MAG_MAX;
          m2_pt_nxt.sat  = 1'b1;
        end else begin
          m2_pt_nxt.m[i] = m2_p[i][30:0];
        end
      end
      if (m2_p[3] > 64'hffffffff) begin
        m2_pt_nxt.de  = 32'hffffffff;
        m2_pt_nxt.sat = 1'b1;
      end else begin
        m2_pt_nxt.de = m2_p[3][31:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // G1/G2: global scale, derivative = de*|scale| + 1.0
  // ---------------------------------------------------------------------------
  logic             g1_valid_r, g2_valid_r;
  logic             g1_sat_r;
  logic [31:0]      mag_s;
  logic [3:0][63:0] g1_pr_r, g1_pr_nxt;
  logic [3:0][63:0] g2_p;
  logic [63:0]      g2_dd;
  logic [2:0][31:0] g2_v_r, g2_v_nxt;
  logic [31:0]      g2_de_r, g2_de_nxt;
  logic             g2_sat_r, g2_sat_nxt;

  always_comb begin
    mag_s = scale_r[31] ? (~scale_r + 32'd1) : scale_r;
    for (int i = 0; i < 3; i++) begin
      g1_pr_nxt[i] = 64'(m2_pt_r.m[i]) * 64'(mag_s);
    end
    g1_pr_nxt[3] = 64'(m2_pt_r.de) * 64'(mag_s);
  end

  always_comb begin
    g2_sat_nxt = g1_sat_r;
    for (int i = 0; i < 4; i++) begin
      g2_p[i] = g1_pr_r[i] >> FB;
    end
    for (int i = 0; i < 3; i++) begin
      if (scale_r[31]) begin
        if (g2_p[i] > 64'h80000000) begin
          g2_v_nxt[i] = 32'h80000000;
          g2_sat_nxt  = 1'b1;
        end else begin
          g2_v_nxt[i] = 32'd0 - g2_p[i][31:0];
        end
      end else if (g2_p[i] > 64'h7fffffff) begin
        g2_v_nxt[i] = 32'h7fffffff;
        g2_sat_nxt  = 1'b1;
      end else begin
        g2_v_nxt[i] = g2_p[i][31:0];
      end
    end
    g2_dd = g2_p[3] + ONE_64;
    if (g2_dd > 64'hffffffff) begin
      g2_de_nxt  = 32'hffffffff;
      g2_sat_nxt = 1'b1;
    end else begin
      g2_de_nxt = g2_dd[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // R1/R2: optional 3x3 rotation, Q2.16 coefficients, truncate toward zero
  // ---------------------------------------------------------------------------
  logic                   r1_valid_r;
  logic [2:0][31:0]       r1_v_r;
  logic [31:0]            r1_de_r;
  logic                   r1_sat_r;
  logic signed [49:0]     r1_pr_r  [3][3];
  logic signed [49:0]     r1_pr_nxt[3][3];
  logic signed [ffi_pkg::COEF_W-1:0] cf [3][3];
  logic signed [51:0]     acc [3];
  logic [51:0]            acc_mag [3];
  logic [51:0]            acc_sh [3];
  logic signed [51:0]     acc_tr [3];
  logic [2:0][31:0]       rot_w;
  logic                   rot_sat;
  logic                   out_strobe_r;
  ffi_pkg::ffi_out_t      out_item_r, out_item_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        cf[i][k]        = rot_row_r[i][ffi_pkg::COEF_W*k +: ffi_pkg::COEF_W];
        r1_pr_nxt[i][k] = cf[i][k] * $signed(g2_v_r[k]);
      end
    end
  end

  always_comb begin
    rot_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc[i] = {{2{r1_pr_r[i][0][49]}}, r1_pr_r[i][0]}
             + {{2{r1_pr_r[i][1][49]}}, r1_pr_r[i][1]}
             + {{2{r1_pr_r[i][2][49]}}, r1_pr_r[i][2]};
      acc_mag[i] = acc[i][51] ? (~acc[i] + 52'd1) : acc[i];
      acc_sh[i]  = acc_mag[i] >> ffi_pkg::COEF_FRAC;
      acc_tr[i]  = acc[i][51] ? $signed(~acc_sh[i] + 52'd1) : $signed(acc_sh[i]);
      if (acc_tr[i] > 52'sh7fffffff) begin
        rot_w[i] = 32'h7fffffff;
        rot_sat  = 1'b1;
      end else if (acc_tr[i] < -52'sh80000000) begin
        rot_w[i] = 32'h80000000;
        rot_sat  = 1'b1;
      end else begin
        rot_w[i] = acc_tr[i][31:0];
      end
    end
    out_item_nxt.deriv_out = r1_de_r;
    if (rot_en_r) begin
      out_item_nxt.new_x     = rot_w[0];
      out_item_nxt.new_y     = rot_w[1];
      out_item_nxt.new_z     = rot_w[2];
      out_item_nxt.saturated = r1_sat_r || rot_sat;
    end else begin
      out_item_nxt.new_x     = r1_v_r[0];
      out_item_nxt.new_y     = r1_v_r[1];
      out_item_nxt.new_z     = r1_v_r[2];
      out_item_nxt.saturated = r1_sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r   <= 1'b0;
      m2_valid_r   <= 1'b0;
      g1_valid_r   <= 1'b0;
      g2_valid_r   <= 1'b0;
      r1_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      m1_valid_r   <= d_valid_r[QW];
      m2_valid_r   <= m1_valid_r;
      g1_valid_r   <= m2_valid_r;
      g2_valid_r   <= g1_valid_r;
      r1_valid_r   <= g2_valid_r;
      out_strobe_r <= r1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_pt_r    <= d_pt_r[QW];
    m1_fold_r  <= d_fold_r[QW];
    m1_pl_r    <= m1_pl_nxt;
    m1_ph_r    <= m1_ph_nxt;
    m2_pt_r    <= m2_pt_nxt;
    g1_pr_r    <= g1_pr_nxt;
    g1_sat_r   <= m2_pt_r.sat;
    g2_v_r     <= g2_v_nxt;
    g2_de_r    <= g2_de_nxt;
    g2_sat_r   <= g2_sat_nxt;
    r1_pr_r    <= r1_pr_nxt;
    r1_v_r     <= g2_v_r;
    r1_de_r    <= g2_de_r;
    r1_sat_r   <= g2_sat_r;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef ASSERT_OFF
  // every result goes back to a matching input transfer
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without matching input transfer");

  // the divider chain keeps its valid bits in step
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r[QW] |-> $past(d_valid_r[0], QW))
    else $error("divider valid out of step");

  // a fold never divides by zero
  a_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r[0] && d_fold_r[0] |-> d_dvs_r[0] != 32'd0)
    else $error("fold selected with zero divisor");

  // derivative always carries the +1.0 term
  a_de: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> 64'(out_item.deriv_out) >= ONE_64)
    else $error("derivative below one");
`endif

endmodule
